// ----- sv/lsp_pkg.sv -----
package lsp_pkg;

   // Field and register widths
   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 16;
   localparam int ADDR_W   = 16;
   localparam int LEN_W    = 17;
   localparam int STEP_W   = 18;
   localparam int POS_W    = 32;
   localparam int INDEX_W  = 3;
   localparam int CSR_W    = 18;

   // Number of entries in the sample store; longer buffer lengths are limited to it
   localparam logic [LEN_W-1:0] BUF_DEPTH = LEN_W'(65536);

   // Remainder unit operand width, wide enough for loop start plus position
   localparam int DIV_W     = LEN_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // The quiet scaling is floor((4v + 5 + 10 * 13107) / 10) - 13107. The biased
   // dividend stays below 2^18, so the divide by ten is a multiply by
   // ceil(2^19 / 10) followed by a right shift by 19.
   localparam int                       QUIET_W       = 18;
   localparam int                       QUIET_RECIP_W = 16;
   localparam logic [QUIET_W-1:0]       QUIET_BIAS    = QUIET_W'(131075);
   localparam logic [QUIET_RECIP_W-1:0] QUIET_RECIP   = QUIET_RECIP_W'(52429);
   localparam int                       QUIET_SHIFT   = 19;
   localparam logic [SAMPLE_W-1:0]      QUIET_OFFSET  = SAMPLE_W'(13107);

   // Rounding constant for the interpolation product
   localparam logic signed [2*LEN_W-1:0] ROUND_HALF = (2*LEN_W)'(32768);

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

   // Register indexes of the configuration port
   localparam logic [INDEX_W-1:0] REG_LOOP_START  = 3'd0;
   localparam logic [INDEX_W-1:0] REG_LOOP_LENGTH = 3'd1;
   localparam logic [INDEX_W-1:0] REG_BUF_LENGTH  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_STEP        = 3'd3;
   localparam logic [INDEX_W-1:0] REG_QUIET       = 3'd4;

   // Request modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_RD_A,
      ST_RD_B,
      ST_MUL,
      ST_ADD,
      ST_SCALE,
      ST_QUIET,
      ST_FINISH
   } state_type;

   // Status handed back by the remainder unit
   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] rem;
   } div_status_type;

endpackage

// ----- sv/lsp_div.sv -----
// Restoring remainder unit that handles one dividend bit per cycle.
module lsp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsp_pkg::DIV_W-1:0]    dividend,
   input  logic [lsp_pkg::LEN_W-1:0]    divisor,
   output lsp_pkg::div_status_type      status
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lsp_pkg::DIV_CNT_W-1:0]     count_ff, count_in;
   logic [lsp_pkg::DIV_W-1:0]         dvd_ff, dvd_in;
   logic [lsp_pkg::LEN_W-1:0]         dvs_ff, dvs_in;
   logic [lsp_pkg::LEN_W-1:0]         rem_ff, rem_in;
   logic [lsp_pkg::LEN_W:0]           trial;
   logic                              fits;

   // One trial subtraction of the running remainder.
   always_comb begin
      trial = {rem_ff, dvd_ff[lsp_pkg::DIV_W-1]};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // Sequencing of the iterations.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = lsp_pkg::DIV_CNT_W'(lsp_pkg::DIV_W - 1);
         dvd_in   = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[lsp_pkg::DIV_W-2:0], 1'b0};
         if (fits) begin
            rem_in = lsp_pkg::LEN_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[lsp_pkg::LEN_W-1:0];
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - lsp_pkg::DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

// ----- sv/lsp_mem.sv -----
// Sample store: one write port and one read port with registered read data.
module lsp_mem (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [lsp_pkg::ADDR_W-1:0]          wr_addr,
   input  logic signed [lsp_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [lsp_pkg::ADDR_W-1:0]          rd_addr,
   output logic signed [lsp_pkg::SAMPLE_W-1:0] rd_data
);

   logic signed [lsp_pkg::SAMPLE_W-1:0] store_ff [0:(1 << lsp_pkg::ADDR_W)-1];
   logic signed [lsp_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/looped_sample_player_lerp_core.sv -----
// A load request leaves the core idle, so loads can follow back to back.
// A tick with an empty buffer or loop goes straight to the finish state and then to the result register.
// A playing tick passes through the modulo wrap, both sample reads, multiply, add and scale states,
// plus the quiet state with quiet scaling; the modulo wrap runs 17 steps on the remainder unit.
// A stalled result keeps the next tick in its finish state, and the input stalls meanwhile.
// Synchronous active-high reset resets the read position, state and configuration registers; the store is not cleared.
module looped_sample_player_lerp_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [lsp_pkg::ADDR_W-1:0]          req_load_address,
   input  logic signed [lsp_pkg::SAMPLE_W-1:0] req_load_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lsp_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsp_pkg::INDEX_W-1:0]         csr_index,
   input  logic [lsp_pkg::CSR_W-1:0]           csr_wdata
);

   lsp_pkg::state_type state_ff, state_in;

   logic [lsp_pkg::ADDR_W-1:0]   loop_start_ff;
   logic [lsp_pkg::LEN_W-1:0]    loop_len_ff;
   logic [lsp_pkg::LEN_W-1:0]    buf_len_ff;
   logic [lsp_pkg::STEP_W-1:0]   step_ff;
   logic                         quiet_ff;

   logic [lsp_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [lsp_pkg::ADDR_W-1:0]   idx2_ff, idx2_in;
   logic signed [lsp_pkg::SAMPLE_W-1:0]  a_ff, a_in;
   logic signed [2*lsp_pkg::LEN_W-1:0]   prod_ff, prod_in;
   logic signed [lsp_pkg::SAMPLE_W-1:0]  v_ff, v_in;
   logic                         advance_ff, advance_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [lsp_pkg::SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;

   logic                         mem_wr_en;
   logic [lsp_pkg::ADDR_W-1:0]   mem_rd_addr;
   logic signed [lsp_pkg::SAMPLE_W-1:0] mem_rd_data;

   logic                         div_start;
   logic [lsp_pkg::DIV_W-1:0]    div_dividend;
   logic [lsp_pkg::LEN_W-1:0]    div_divisor;
   lsp_pkg::div_status_type      div_status;

   logic                         req_accept;
   logic                         out_free;
   logic [lsp_pkg::LEN_W-1:0]    eff_len;
   logic [lsp_pkg::LEN_W-1:0]    int_pos;
   logic [lsp_pkg::LEN_W-1:0]    next_idx;
   logic signed [lsp_pkg::LEN_W-1:0]    diff;
   logic signed [lsp_pkg::LEN_W-1:0]    frac_s;
   logic signed [2*lsp_pkg::LEN_W-1:0]  rounded;
   logic signed [lsp_pkg::STEP_W-1:0]   lerp_sum;
   logic [lsp_pkg::QUIET_W-1:0]  quiet_dividend;
   logic [2*lsp_pkg::LEN_W-1:0]  quiet_prod;
   logic [lsp_pkg::POS_W:0]      pos_sum;
   logic [lsp_pkg::POS_W:0]      pos_limit;

   lsp_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_load_address),
      .wr_data (req_load_value),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status)
   );

   assign req_stall  = (state_ff != lsp_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Datapath terms shared by the sequencer.
   always_comb begin
      eff_len  = (buf_len_ff > lsp_pkg::BUF_DEPTH) ? lsp_pkg::BUF_DEPTH : buf_len_ff;
      int_pos  = lsp_pkg::LEN_W'(loop_start_ff)
               + lsp_pkg::LEN_W'(pos_ff[lsp_pkg::POS_W-1:lsp_pkg::FRAC_W]);
      next_idx = div_status.rem + lsp_pkg::LEN_W'(1);
      diff     = lsp_pkg::LEN_W'(mem_rd_data) - lsp_pkg::LEN_W'(a_ff);
      frac_s   = $signed({1'b0, pos_ff[lsp_pkg::FRAC_W-1:0]});
      rounded  = (prod_ff + lsp_pkg::ROUND_HALF) >>> lsp_pkg::FRAC_W;
      lerp_sum = lsp_pkg::STEP_W'(a_ff) + rounded[lsp_pkg::STEP_W-1:0];
      quiet_dividend = lsp_pkg::QUIET_BIAS + lsp_pkg::QUIET_W'({v_ff, 2'b00});
      quiet_prod = (2*lsp_pkg::LEN_W)'(quiet_dividend)
                 * (2*lsp_pkg::LEN_W)'(lsp_pkg::QUIET_RECIP);
      pos_sum   = {1'b0, pos_ff} + (lsp_pkg::POS_W+1)'(step_ff);
      pos_limit = {loop_len_ff, {lsp_pkg::FRAC_W{1'b0}}};
   end

   // Sequencer: next state, datapath loads and the result handoff.
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      idx2_in       = idx2_ff;
      a_in          = a_ff;
      prod_in       = prod_ff;
      v_in          = v_ff;
      advance_in    = advance_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      mem_wr_en     = 1'b0;
      mem_rd_addr   = idx2_ff;
      div_start     = 1'b0;
      div_dividend  = int_pos;
      div_divisor   = eff_len;
      case (state_ff)
         lsp_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == lsp_pkg::MODE_LOAD) begin
                  mem_wr_en = 1'b1;
               end else if (buf_len_ff == '0 || loop_len_ff == '0) begin
                  v_in       = '0;
                  advance_in = 1'b0;
                  state_in   = lsp_pkg::ST_FINISH;
               end else begin
                  div_start  = 1'b1;
                  advance_in = 1'b1;
                  state_in   = lsp_pkg::ST_MOD;
               end
            end
         end
         lsp_pkg::ST_MOD: begin
            if (div_status.done) begin
               mem_rd_addr = div_status.rem[lsp_pkg::ADDR_W-1:0];
               if (next_idx == eff_len) begin
                  idx2_in = '0;
               end else begin
                  idx2_in = next_idx[lsp_pkg::ADDR_W-1:0];
               end
               state_in = lsp_pkg::ST_RD_A;
            end
         end
         lsp_pkg::ST_RD_A: begin
            // First sample arrives; second address goes out.
            a_in     = mem_rd_data;
            state_in = lsp_pkg::ST_RD_B;
         end
         lsp_pkg::ST_RD_B: begin
            state_in = lsp_pkg::ST_MUL;
         end
         lsp_pkg::ST_MUL: begin
            // a + (b - a) * f is the same as a * (1 - f) + b * f.
            prod_in  = (2*lsp_pkg::LEN_W)'(diff) * (2*lsp_pkg::LEN_W)'(frac_s);
            state_in = lsp_pkg::ST_ADD;
         end
         lsp_pkg::ST_ADD: begin
            v_in     = lerp_sum[lsp_pkg::SAMPLE_W-1:0];
            state_in = lsp_pkg::ST_SCALE;
         end
         lsp_pkg::ST_SCALE: begin
            if (quiet_ff) begin
               // The divide by ten of the quiet scaling is a reciprocal multiply.
               prod_in  = $signed(quiet_prod);
               state_in = lsp_pkg::ST_QUIET;
            end else begin
               state_in = lsp_pkg::ST_FINISH;
            end
         end
         lsp_pkg::ST_QUIET: begin
            v_in     = lsp_pkg::SAMPLE_W'(prod_ff[2*lsp_pkg::LEN_W-1:lsp_pkg::QUIET_SHIFT])
                     - lsp_pkg::QUIET_OFFSET;
            state_in = lsp_pkg::ST_FINISH;
         end
         lsp_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = v_ff;
               if (advance_ff) begin
                  if (pos_sum >= pos_limit) begin
                     pos_in = '0;
                  end else begin
                     pos_in = pos_sum[lsp_pkg::POS_W-1:0];
                  end
               end
               state_in = lsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsp_pkg::ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         advance_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         advance_ff   <= advance_in;
      end
      idx2_ff       <= idx2_in;
      a_ff          <= a_in;
      prod_ff       <= prod_in;
      v_ff          <= v_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_start_ff <= '0;
         loop_len_ff   <= '0;
         buf_len_ff    <= '0;
         step_ff       <= lsp_pkg::STEP_RESET;
         quiet_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lsp_pkg::REG_LOOP_START:  loop_start_ff <= csr_wdata[lsp_pkg::ADDR_W-1:0];
            lsp_pkg::REG_LOOP_LENGTH: loop_len_ff   <= csr_wdata[lsp_pkg::LEN_W-1:0];
            lsp_pkg::REG_BUF_LENGTH:  buf_len_ff    <= csr_wdata[lsp_pkg::LEN_W-1:0];
            lsp_pkg::REG_STEP:        step_ff       <= csr_wdata[lsp_pkg::STEP_W-1:0];
            lsp_pkg::REG_QUIET:       quiet_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule
